>>> hw/rtl/sm83_pkg.sv
`timescale 1ns / 1ps
// Shared constants and datapath functions for the SM83 instruction executor.
// No dependencies.
package sm83_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

	localparam logic [15:0] HIGH_PAGE = 16'hFF00;
	localparam logic [7:0]  CB_PREFIX = 8'hCB;
	localparam logic [7:0]  FZ        = 8'h80;
	localparam logic [7:0]  FN        = 8'h40;
	localparam logic [7:0]  FH        = 8'h20;
	localparam logic [7:0]  FC        = 8'h10;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_EXEC    = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	// returns {A, F}
	function automatic logic [15:0] alu_op(logic [2:0] grp, logic [7:0] a, logic [7:0] v);
		logic [8:0] s;
		logic [7:0] r;
		logic [4:0] hs;
		s  = {1'b0, a} + {1'b0, v};
		hs = {1'b0, a[3:0]} + {1'b0, v[3:0]};
		r  = 8'h00;
		case (grp)
			ALU_ADD: alu_op = {s[7:0], s[7:0] == 8'h00, 1'b0, hs[4], s[8], 4'h0};
			ALU_SUB, ALU_CP: begin
				r = a - v;
				alu_op = {(grp == ALU_SUB) ? r : a, r == 8'h00, 1'b1, a[3:0] < v[3:0], v > a, 4'h0};
			end
			ALU_AND: begin
				r = a & v;
				alu_op = {r, r == 8'h00, 1'b0, 1'b1, 1'b0, 4'h0};
			end
			ALU_XOR: begin
				r = a ^ v;
				alu_op = {r, r == 8'h00, 3'b000, 4'h0};
			end
			default: begin
				r = a | v;
				alu_op = {r, r == 8'h00, 3'b000, 4'h0};
			end
		endcase
	endfunction

	function automatic logic op_valid(logic [7:0] op, logic [7:0] n);
		logic [2:0] d;
		logic [2:0] s;
		d = op[5:3];
		s = op[2:0];
		if (op[7:6] == 2'b01) begin
			op_valid = op != 8'h76;
		end else if (op[7:6] == 2'b10) begin
			op_valid = !(d == 3'd1 || d == 3'd3) && !(s == 3'd6 && d inside {[3'd4:3'd6]});
		end else if (op[7:6] == 2'b00 && d != 3'd6 && s inside {3'd4, 3'd5, 3'd6}) begin
			op_valid = 1'b1;
		end else if (op == CB_PREFIX) begin
			op_valid = n[2:0] != 3'd6 &&
				(n[7:6] == 2'b01 || n inside {[8'h00:8'h07], [8'h10:8'h17]});
		end else begin
			op_valid = op inside {8'h00, 8'h01, 8'h11, 8'h21, 8'h31, 8'h0A, 8'h1A, 8'h02,
				8'h12, 8'hE2, 8'hF2, 8'h36, 8'h22, 8'h32, 8'h2A, 8'h3A, 8'hE0, 8'hF0,
				8'hEA, 8'hFA, 8'hF5, 8'hC5, 8'hD5, 8'hE5, 8'hF1, 8'hC1, 8'hD1, 8'hE1,
				8'hC6, 8'hD6, 8'hFE, 8'h2F, 8'h03, 8'h13, 8'h23, 8'h33, 8'h0B, 8'h1B,
				8'h2B, 8'h3B, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38, 8'hC3, 8'hCD, 8'hF3,
				8'hFB, 8'hC9, 8'hD9, 8'h07, 8'h17};
		end
	endfunction

endpackage

>>> hw/rtl/sm83_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM, registered read, read data held when idle.
// No dependencies.
module sm83_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> hw/rtl/sm83_instruction_executor.sv
`timescale 1ns / 1ps
// SM83 instruction executor top level: sequencer, register file and result register.
// Depends on sm83_pkg and sm83_ram.
//
// Each word on the input stream is one operation on a 64 KiB byte memory held in a
// single-port RAM, and is finished before the next is taken. A byte write or a restart
// passes S_DONE and a byte read S_RD, where the result word is registered. An execute
// steps through S_F1, S_F2, S_F3, S_EX, S_M1 and S_WB, where its result is registered.
// The single RAM port sets this: opcode, two immediate bytes, a spare state while the
// last byte lands, then up to two data or stack accesses in turn. A result that is not
// taken stalls the next word at its last state until it is. The memory has no clearing
// pass and is available straight after reset. The result sits in an output register,
// so the next word is taken while a result still waits.
module sm83_instruction_executor
	import sm83_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // address[15:0], data[23:16]
	input  logic [1:0]   s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // cycles_taken[4:0], read_data[12:5], program_counter[28:13],
	                                // stack_pointer[44:29], acc_flags[60:45], pair_bc[76:61],
	                                // pair_de[92:77], pair_hl[108:93], irq_master_enable[109]
	output logic         m_tuser    // fault
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DONE, S_F1, S_F2, S_F3, S_EX, S_M1, S_WB
	} state_t;

	state_t      state_q;
	logic [7:0]  rf_q [8];      // B C D E H L F A
	logic [15:0] sp_q, pc_q, start_q;
	logic        ime_q;
	logic [7:0]  op_q, n_q, nh_q, m0_q;
	logic [111:0] out_q;
	logic        fault_q, mv_q;

	logic        ram_en, ram_we;
	logic [15:0] ram_addr;
	logic [7:0]  ram_wd, ram_rd;

	sm83_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr[MEM_ADDR_BITS-1:0]),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	logic [15:0] pc1, pc2, pc3, bc, de, hl, nn, rel, psh_v;
	logic [2:0]  dd, ss;
	logic        valid, out_free, out_load, psh, pop;
	logic        a0_en, a0_we, a1_en, a1_we;
	logic [15:0] a0_addr, a1_addr;
	logic [7:0]  a0_wd, a1_wd;

	assign pc1   = pc_q + 16'd1;
	assign pc2   = pc_q + 16'd2;
	assign pc3   = pc_q + 16'd3;
	assign bc    = {rf_q[0], rf_q[1]};
	assign de    = {rf_q[2], rf_q[3]};
	assign hl    = {rf_q[4], rf_q[5]};
	assign nn    = {nh_q, n_q};
	assign rel   = pc2 + {{8{n_q[7]}}, n_q};
	assign dd    = op_q[5:3];
	assign ss    = op_q[2:0];
	assign valid = op_valid(op_q, n_q);
	assign out_free = !mv_q || m_tready;
	assign out_load = out_free && (state_q inside {S_RD, S_DONE, S_WB});

	// memory accesses of an instruction, issued in S_EX and S_M1
	always_comb begin
		a0_en = 1'b0; a0_we = 1'b0; a0_addr = 16'h0000; a0_wd = 8'h00;
		a1_en = 1'b0; a1_we = 1'b0; a1_addr = 16'h0000; a1_wd = 8'h00;
		psh = 1'b0; pop = 1'b0; psh_v = 16'h0000;
		if (valid) begin
			if (op_q[7:6] == 2'b01) begin
				if (ss == 3'd6) begin
					a0_en = 1'b1; a0_addr = hl;
				end else if (dd == 3'd6) begin
					a0_en = 1'b1; a0_we = 1'b1; a0_addr = hl; a0_wd = rf_q[ss];
				end
			end else if (op_q[7:6] == 2'b10) begin
				if (ss == 3'd6) begin
					a0_en = 1'b1; a0_addr = hl;
				end
			end else begin
				case (op_q)
					8'h0A: begin a0_en = 1'b1; a0_addr = bc; end
					8'h1A: begin a0_en = 1'b1; a0_addr = de; end
					8'hF2: begin a0_en = 1'b1; a0_addr = HIGH_PAGE + {8'h00, rf_q[1]}; end
					8'h2A, 8'h3A: begin a0_en = 1'b1; a0_addr = hl; end
					8'hF0: begin a0_en = 1'b1; a0_addr = HIGH_PAGE + {8'h00, n_q}; end
					8'hFA: begin a0_en = 1'b1; a0_addr = nn; end
					8'h02: begin a0_en = 1'b1; a0_we = 1'b1; a0_addr = bc; a0_wd = rf_q[7]; end
					8'h12: begin a0_en = 1'b1; a0_we = 1'b1; a0_addr = de; a0_wd = rf_q[7]; end
					8'hE2: begin
						a0_en = 1'b1; a0_we = 1'b1; a0_wd = rf_q[7];
						a0_addr = HIGH_PAGE + {8'h00, rf_q[1]};
					end
					8'h36: begin a0_en = 1'b1; a0_we = 1'b1; a0_addr = hl; a0_wd = n_q; end
					8'h22, 8'h32: begin
						a0_en = 1'b1; a0_we = 1'b1; a0_addr = hl; a0_wd = rf_q[7];
					end
					8'hE0: begin
						a0_en = 1'b1; a0_we = 1'b1; a0_wd = rf_q[7];
						a0_addr = HIGH_PAGE + {8'h00, n_q};
					end
					8'hEA: begin a0_en = 1'b1; a0_we = 1'b1; a0_addr = nn; a0_wd = rf_q[7]; end
					8'hF5: begin psh = 1'b1; psh_v = {rf_q[7], rf_q[6]}; end
					8'hC5: begin psh = 1'b1; psh_v = bc; end
					8'hD5: begin psh = 1'b1; psh_v = de; end
					8'hE5: begin psh = 1'b1; psh_v = hl; end
					8'hCD: begin psh = 1'b1; psh_v = pc3; end
					8'hF1, 8'hC1, 8'hD1, 8'hE1, 8'hC9, 8'hD9: pop = 1'b1;
					default: ;
				endcase
			end
			if (psh) begin
				a0_en = 1'b1; a0_we = 1'b1; a0_addr = sp_q - 16'd1; a0_wd = psh_v[15:8];
				a1_en = 1'b1; a1_we = 1'b1; a1_addr = sp_q - 16'd2; a1_wd = psh_v[7:0];
			end
			if (pop) begin
				a0_en = 1'b1; a0_addr = sp_q;
				a1_en = 1'b1; a1_addr = sp_q + 16'd1;
			end
		end
	end

	// register update, evaluated in S_WB with both access results at hand
	logic [7:0]  nrf [8];
	logic [15:0] nsp, npc;
	logic        nime;
	logic [4:0]  cyc;

	always_comb begin
		logic [15:0] ar;
		logic [15:0] p;
		logic [7:0]  t;
		logic [7:0]  v;
		logic        c;
		logic        f;
		for (int i = 0; i < 8; i++) begin
			nrf[i] = rf_q[i];
		end
		nsp = sp_q; npc = pc_q; nime = ime_q; cyc = 5'd0;
		ar = 16'h0000; p = 16'h0000; t = 8'h00; v = 8'h00; c = 1'b0; f = 1'b0;
		if (valid) begin
			if (op_q[7:6] == 2'b01) begin
				if (ss == 3'd6) begin
					nrf[dd] = m0_q;
				end else if (dd != 3'd6) begin
					nrf[dd] = rf_q[ss];
				end
				npc = pc1;
				cyc = (ss == 3'd6 || dd == 3'd6) ? 5'd8 : 5'd4;
			end else if (op_q[7:6] == 2'b10) begin
				ar = alu_op(dd, rf_q[7], (ss == 3'd6) ? m0_q : rf_q[ss]);
				nrf[7] = ar[15:8]; nrf[6] = ar[7:0];
				npc = pc1;
				cyc = (ss == 3'd6) ? 5'd8 : 5'd4;
			end else if (op_q[7:6] == 2'b00 && dd != 3'd6 &&
					(ss == 3'd4 || ss == 3'd5 || ss == 3'd6)) begin
				if (ss == 3'd6) begin
					nrf[dd] = n_q; npc = pc2; cyc = 5'd8;
				end else begin
					if (ss == 3'd4) begin
						t = rf_q[dd] + 8'd1;
						nrf[6] = {t == 8'h00, 1'b0, t[3:0] == 4'h0, rf_q[6][4], 4'h0};
					end else begin
						t = rf_q[dd] - 8'd1;
						nrf[6] = {t == 8'h00, 1'b1, t[3:0] == 4'hF, rf_q[6][4], 4'h0};
					end
					nrf[dd] = t; npc = pc1; cyc = 5'd4;
				end
			end else begin
				case (op_q)
					8'h00: begin npc = pc1; cyc = 5'd4; end
					8'h01: begin nrf[0] = nh_q; nrf[1] = n_q; npc = pc3; cyc = 5'd12; end
					8'h11: begin nrf[2] = nh_q; nrf[3] = n_q; npc = pc3; cyc = 5'd12; end
					8'h21: begin nrf[4] = nh_q; nrf[5] = n_q; npc = pc3; cyc = 5'd12; end
					8'h31: begin nsp = nn; npc = pc3; cyc = 5'd12; end
					8'h0A, 8'h1A, 8'hF2: begin nrf[7] = m0_q; npc = pc1; cyc = 5'd8; end
					8'h02, 8'h12, 8'hE2: begin npc = pc1; cyc = 5'd8; end
					8'h36: begin npc = pc2; cyc = 5'd12; end
					8'h22, 8'h32, 8'h2A, 8'h3A: begin
						p = op_q[4] ? hl - 16'd1 : hl + 16'd1;
						nrf[4] = p[15:8]; nrf[5] = p[7:0];
						if (op_q[3]) begin
							nrf[7] = m0_q;
						end
						npc = pc1; cyc = 5'd8;
					end
					8'hE0: begin npc = pc2; cyc = 5'd12; end
					8'hF0: begin nrf[7] = m0_q; npc = pc2; cyc = 5'd12; end
					8'hEA: begin npc = pc3; cyc = 5'd16; end
					8'hFA: begin nrf[7] = m0_q; npc = pc3; cyc = 5'd16; end
					8'hF5, 8'hC5, 8'hD5, 8'hE5: begin
						nsp = sp_q - 16'd2; npc = pc1; cyc = 5'd16;
					end
					8'hF1: begin
						nrf[7] = ram_rd; nrf[6] = {m0_q[7:4], 4'h0};
						nsp = sp_q + 16'd2; npc = pc1; cyc = 5'd12;
					end
					8'hC1: begin
						nrf[0] = ram_rd; nrf[1] = m0_q; nsp = sp_q + 16'd2; npc = pc1; cyc = 5'd12;
					end
					8'hD1: begin
						nrf[2] = ram_rd; nrf[3] = m0_q; nsp = sp_q + 16'd2; npc = pc1; cyc = 5'd12;
					end
					8'hE1: begin
						nrf[4] = ram_rd; nrf[5] = m0_q; nsp = sp_q + 16'd2; npc = pc1; cyc = 5'd12;
					end
					8'hC6, 8'hD6, 8'hFE: begin
						ar = alu_op((op_q == 8'hC6) ? ALU_ADD : (op_q == 8'hD6) ? ALU_SUB : ALU_CP,
							rf_q[7], n_q);
						nrf[7] = ar[15:8]; nrf[6] = ar[7:0];
						npc = pc2; cyc = 5'd8;
					end
					8'h2F: begin
						nrf[7] = ~rf_q[7]; nrf[6] = rf_q[6] | FN | FH; npc = pc1; cyc = 5'd4;
					end
					8'h03, 8'h0B: begin
						p = op_q[3] ? bc - 16'd1 : bc + 16'd1;
						nrf[0] = p[15:8]; nrf[1] = p[7:0]; npc = pc1; cyc = 5'd8;
					end
					8'h13, 8'h1B: begin
						p = op_q[3] ? de - 16'd1 : de + 16'd1;
						nrf[2] = p[15:8]; nrf[3] = p[7:0]; npc = pc1; cyc = 5'd8;
					end
					8'h23, 8'h2B: begin
						p = op_q[3] ? hl - 16'd1 : hl + 16'd1;
						nrf[4] = p[15:8]; nrf[5] = p[7:0]; npc = pc1; cyc = 5'd8;
					end
					8'h33: begin nsp = sp_q + 16'd1; npc = pc1; cyc = 5'd8; end
					8'h3B: begin nsp = sp_q - 16'd1; npc = pc1; cyc = 5'd8; end
					8'h18: begin npc = rel; cyc = 5'd12; end
					8'h20, 8'h28, 8'h30, 8'h38: begin
						f = op_q[4] ? rf_q[6][4] : rf_q[6][7];
						if (f != op_q[3]) begin
							npc = pc2; cyc = 5'd8;
						end else begin
							npc = rel; cyc = 5'd12;
						end
					end
					8'hC3: begin npc = nn; cyc = 5'd16; end
					8'hCD: begin nsp = sp_q - 16'd2; npc = nn; cyc = 5'd24; end
					8'hF3: begin nime = 1'b0; npc = pc1; cyc = 5'd4; end
					8'hFB: begin nime = 1'b1; npc = pc1; cyc = 5'd4; end
					8'hC9, 8'hD9: begin
						if (op_q[4]) begin
							nime = 1'b1;
						end
						npc = {ram_rd, m0_q}; nsp = sp_q + 16'd2; cyc = 5'd16;
					end
					8'h07, 8'h17: begin
						c = rf_q[7][7];
						nrf[7] = {rf_q[7][6:0], op_q[4] ? rf_q[6][4] : c};
						nrf[6] = {3'b000, c, 4'h0};
						npc = pc1; cyc = 5'd4;
					end
					CB_PREFIX: begin
						v = rf_q[n_q[2:0]];
						if (n_q[7:6] == 2'b01) begin
							nrf[6] = {~v[n_q[5:3]], 1'b0, 1'b1, rf_q[6][4], 4'h0};
						end else begin
							c = v[7];
							t = {v[6:0], n_q[4] ? rf_q[6][4] : c};
							nrf[n_q[2:0]] = t;
							nrf[6] = {t == 8'h00, 2'b00, c, 4'h0};
						end
						npc = pc2; cyc = 5'd8;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		ram_en = 1'b0; ram_we = 1'b0; ram_addr = 16'h0000; ram_wd = 8'h00;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						OP_WRITE: begin
							ram_en = 1'b1; ram_we = 1'b1; ram_addr = s_tdata[15:0];
							ram_wd = s_tdata[23:16];
						end
						OP_READ: begin ram_en = 1'b1; ram_addr = s_tdata[15:0]; end
						OP_EXEC: begin ram_en = 1'b1; ram_addr = pc_q; end
						default: ;
					endcase
				end
			end
			S_F1: begin ram_en = 1'b1; ram_addr = pc1; end
			S_F2: begin ram_en = 1'b1; ram_addr = pc2; end
			S_EX: begin ram_en = a0_en; ram_we = a0_we; ram_addr = a0_addr; ram_wd = a0_wd; end
			S_M1: begin ram_en = a1_en; ram_we = a1_we; ram_addr = a1_addr; ram_wd = a1_wd; end
			default: ;
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;
	assign m_tuser  = fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 8'h00;
			end
			sp_q    <= 16'h0000;
			pc_q    <= 16'h0000;
			ime_q   <= 1'b0;
			start_q <= 16'd256;
			mv_q    <= 1'b0;
			fault_q <= 1'b0;
			out_q   <= '0;
			op_q    <= 8'h00;
			n_q     <= 8'h00;
			nh_q    <= 8'h00;
			m0_q    <= 8'h00;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_data;
			end
			if (mv_q && m_tready && !out_load) begin
				mv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							OP_READ: state_q <= S_RD;
							OP_EXEC: state_q <= S_F1;
							OP_RESTART: begin pc_q <= start_q; state_q <= S_DONE; end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_F1: begin op_q <= ram_rd; state_q <= S_F2; end
				S_F2: begin n_q <= ram_rd; state_q <= S_F3; end
				S_F3: begin nh_q <= ram_rd; state_q <= S_EX; end
				S_EX: state_q <= S_M1;
				S_M1: begin m0_q <= ram_rd; state_q <= S_WB; end
				S_RD, S_DONE: begin
					if (out_free) begin
						mv_q    <= 1'b1;
						fault_q <= 1'b0;
						out_q   <= {2'b00, ime_q, hl, de, bc, rf_q[7], rf_q[6], sp_q, pc_q,
							(state_q == S_RD) ? ram_rd : 8'h00, 5'd0};
						state_q <= S_IDLE;
					end
				end
				S_WB: begin
					if (out_free) begin
						for (int i = 0; i < 8; i++) begin
							rf_q[i] <= nrf[i];
						end
						sp_q    <= nsp;
						pc_q    <= npc;
						ime_q   <= nime;
						mv_q    <= 1'b1;
						fault_q <= !valid;
						out_q   <= {2'b00, nime, nrf[4], nrf[5], nrf[2], nrf[3], nrf[0], nrf[1],
							nrf[7], nrf[6], nsp, npc, 8'h00, cyc};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
